// File: hw/rtl/adc_pkg.sv
// adc_pkg: shared types and constants for the ancestor closure counter.
// Depends on nothing; every other file in hw/rtl imports it.
`timescale 1ns / 1ps
package adc_pkg;
	localparam int CFG_W  = 7;
	localparam int NODE_W = 6;
	localparam int RES_W  = 7;
	localparam int IDX_W  = 2;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

	localparam logic [IDX_W-1:0] REG_NODE_COUNT     = 2'd0;
	localparam logic [IDX_W-1:0] REG_THRESHOLD_LOW  = 2'd1;
	localparam logic [IDX_W-1:0] REG_THRESHOLD_HIGH = 2'd2;

	typedef struct packed {
		logic              op;
		logic [NODE_W-1:0] from_node;
		logic [NODE_W-1:0] to_node;
	} cmd_t;

	typedef struct packed {
		logic [RES_W-1:0] count_within_low;
		logic [RES_W-1:0] count_within_high;
		logic [RES_W-1:0] count_over_high;
	} result_t;

	// Controls from the sequencer to the count unit
	typedef struct packed {
		logic clr;
		logic acc_en;
		logic tally_en;
	} cu_ctrl_t;
endpackage

// File: hw/rtl/adc_edge_store.sv
// adc_edge_store: adjacency rows and in-degree memories, with edge load and clearing pass.
// Depends on adc_pkg.
`timescale 1ns / 1ps
module adc_edge_store #(
	parameter int MAX_NODES = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                ld_en,
	input  logic [adc_pkg::NODE_W-1:0]          ld_from,
	input  logic [adc_pkg::NODE_W-1:0]          ld_to,
	output logic                                busy,
	input  logic [$clog2(MAX_NODES)-1:0]        row_addr,
	input  logic [$clog2(MAX_NODES)-1:0]        deg_addr,
	output logic [MAX_NODES-1:0]                row_data,
	output logic [$clog2(MAX_NODES+1)-1:0]      deg_data
);
	import adc_pkg::*;

	localparam int NW = $clog2(MAX_NODES);
	localparam int DW = $clog2(MAX_NODES+1);
	localparam logic [NW-1:0] LAST = NW'(MAX_NODES - 1);

	logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
	logic [DW-1:0]        pend_mem [MAX_NODES];

	logic          clearing_q;
	logic [NW-1:0] clr_q;
	logic          ld_s1;
	logic          ok_s1;
	logic [NW-1:0] from_s1;
	logic [NW-1:0] to_s1;
	logic [NW-1:0] ra;
	logic [NW-1:0] da;
	logic          ok;
	logic          add_edge;

	assign ok       = (32'(ld_from) < MAX_NODES) && (32'(ld_to) < MAX_NODES);
	assign ra       = ld_en ? NW'(ld_from) : row_addr;
	assign da       = ld_en ? NW'(ld_to) : deg_addr;
	assign add_edge = ld_s1 && ok_s1 && !row_data[to_s1];
	assign busy     = clearing_q || ld_s1;

	// Sweep both memories to zero after reset, track the load write cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
			ld_s1      <= 1'b0;
		end else begin
			ld_s1 <= ld_en;
			if (clearing_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == LAST) clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ok_s1   <= ok;
		from_s1 <= NW'(ld_from);
		to_s1   <= NW'(ld_to);
	end

	// Memories: registered reads, one write port each
	always_ff @(posedge clk) begin
		row_data <= adj_mem[ra];
		deg_data <= pend_mem[da];
		if (clearing_q) begin
			adj_mem[clr_q]  <= '0;
			pend_mem[clr_q] <= '0;
		end else if (add_edge) begin
			adj_mem[from_s1] <= row_data | (MAX_NODES'(1) << to_s1);
			pend_mem[to_s1]  <= deg_data + 1'b1;
		end
	end
endmodule

// File: hw/rtl/adc_count_unit.sv
// adc_count_unit: per-column ancestor counters, row population check and final tally.
// Depends on adc_pkg.
`timescale 1ns / 1ps
module adc_count_unit #(
	parameter int MAX_NODES = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  adc_pkg::cu_ctrl_t               ctrl,
	input  logic [MAX_NODES-1:0]            row,
	input  logic [$clog2(MAX_NODES+1)-1:0]  n,
	input  logic [adc_pkg::CFG_W-1:0]       thr_low,
	input  logic [adc_pkg::CFG_W-1:0]       thr_high,
	output adc_pkg::result_t                result
);
	import adc_pkg::*;

	localparam int DW = $clog2(MAX_NODES+1);
	localparam int CW = (DW + 1 > CFG_W + 1) ? DW + 1 : CFG_W + 1;

	logic [DW-1:0] col_q [MAX_NODES];
	logic [DW-1:0] low_q;
	logic [DW-1:0] high_q;
	logic [DW-1:0] over_q;
	logic [CW-1:0] cnt;
	logic          over;

	assign cnt  = CW'(1) + CW'(n) - CW'(col_q[0]);
	assign over = $countones(row) > 32'(thr_high);

	// Accumulate column sums, then shift them out one node per cycle
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_NODES - 1; i++) begin
			if (ctrl.clr) col_q[i] <= '0;
			else if (ctrl.acc_en) col_q[i] <= col_q[i] + DW'(row[i]);
			else if (ctrl.tally_en) col_q[i] <= col_q[i+1];
		end
		if (ctrl.clr) col_q[MAX_NODES-1] <= '0;
		else if (ctrl.acc_en) col_q[MAX_NODES-1] <= col_q[MAX_NODES-1] + DW'(row[MAX_NODES-1]);
		else if (ctrl.tally_en) col_q[MAX_NODES-1] <= '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= '0;
			over_q <= '0;
		end else if (ctrl.clr) begin
			low_q  <= '0;
			high_q <= '0;
			over_q <= '0;
		end else begin
			if (ctrl.acc_en && over) over_q <= over_q + 1'b1;
			if (ctrl.tally_en) begin
				if (cnt <= CW'(thr_low))  low_q  <= low_q + 1'b1;
				if (cnt <= CW'(thr_high)) high_q <= high_q + 1'b1;
			end
		end
	end

	assign result.count_within_low  = RES_W'(low_q);
	assign result.count_within_high = RES_W'(high_q);
	assign result.count_over_high   = RES_W'(over_q);
endmodule

// File: hw/rtl/dag_ancestor_closure_counter.sv
// dag_ancestor_closure_counter: top level, Kahn sequencer with degree, ancestor and queue memories.
// Depends on adc_pkg, adc_edge_store and adc_count_unit.
//
//   channel   | handshake            | payload
//   command   | start / busy         | cmd (cmd_t)
//   result    | done (1-cycle pulse) | result (result_t)
//   config    | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// After reset the edge memories are cleared with busy high.
// An edge load is a read, then a write back.
// A compute holds busy through init, the Kahn walk over the ready queue, the column
// count and the tally; the bit-serial scan of each adjacency row sets the pace.
// done marks its last cycle.
// The result is valid with done and holds until the next compute starts; the receiver cannot stall it.
`timescale 1ns / 1ps
module dag_ancestor_closure_counter #(
	parameter int MAX_NODES = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  adc_pkg::cmd_t                 cmd,
	output logic                          done,
	output adc_pkg::result_t              result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [adc_pkg::IDX_W-1:0]     cfg_index,
	input  logic [adc_pkg::CFG_W-1:0]     cfg_data
);
	import adc_pkg::*;

	localparam int NW = $clog2(MAX_NODES);
	localparam int DW = $clog2(MAX_NODES+1);
	localparam logic [NW-1:0] LAST = NW'(MAX_NODES - 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_INIT  = 4'd1;
	localparam logic [3:0] S_INITD = 4'd2;
	localparam logic [3:0] S_POP   = 4'd3;
	localparam logic [3:0] S_POPW  = 4'd4;
	localparam logic [3:0] S_ROWW  = 4'd5;
	localparam logic [3:0] S_SCAN  = 4'd6;
	localparam logic [3:0] S_UPD   = 4'd7;
	localparam logic [3:0] S_CNT   = 4'd8;
	localparam logic [3:0] S_CNTD  = 4'd9;
	localparam logic [3:0] S_TALLY = 4'd10;
	localparam logic [3:0] S_DONE  = 4'd11;

	logic [3:0]     state_q;
	logic [CFG_W-1:0] node_count_q;
	logic [CFG_W-1:0] thr_low_q;
	logic [CFG_W-1:0] thr_high_q;
	logic [DW-1:0]  n_q;
	logic [NW-1:0]  i_q;
	logic [NW-1:0]  v_q;
	logic [DW-1:0]  k_q;
	logic [DW-1:0]  head_q;
	logic [DW-1:0]  tail_q;
	logic           iv_s1;
	logic [NW-1:0]  idx_s1;
	logic           cv_s1;
	logic [MAX_NODES-1:0] row_q;
	logic [MAX_NODES-1:0] ancu_q;

	logic [MAX_NODES-1:0] anc_mem [MAX_NODES];
	logic [DW-1:0]        deg_mem [MAX_NODES];
	logic [NW-1:0]        q_mem   [MAX_NODES];
	logic [MAX_NODES-1:0] anc_rd;
	logic [DW-1:0]        deg_rd;
	logic [NW-1:0]        q_rd;

	logic                 es_busy;
	logic                 ld_en;
	logic                 accept;
	logic [NW-1:0]        row_addr;
	logic [NW-1:0]        deg_addr;
	logic [MAX_NODES-1:0] es_row;
	logic [DW-1:0]        es_deg;

	logic [NW-1:0]        anc_ra;
	logic                 anc_we;
	logic [NW-1:0]        anc_wa;
	logic [MAX_NODES-1:0] anc_wd;
	logic                 deg_we;
	logic [DW-1:0]        deg_wd;
	logic                 push;
	logic [NW-1:0]        push_node;
	logic [DW-1:0]        new_deg;
	logic                 idx_in;
	logic [DW-1:0]        n_eff;
	cu_ctrl_t             cu_ctrl;

	assign busy      = (state_q != S_IDLE) || es_busy;
	assign accept    = start && !busy;
	assign ld_en     = accept && (cmd.op == OP_LOAD);
	assign cfg_ready = 1'b1;
	assign done      = (state_q == S_DONE);
	assign n_eff     = (32'(node_count_q) < MAX_NODES) ? DW'(node_count_q) : DW'(MAX_NODES);

	adc_edge_store #(.MAX_NODES(MAX_NODES)) u_edges (
		.clk(clk), .arst_n(arst_n), .ld_en(ld_en),
		.ld_from(cmd.from_node), .ld_to(cmd.to_node), .busy(es_busy),
		.row_addr(row_addr), .deg_addr(deg_addr),
		.row_data(es_row), .deg_data(es_deg)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CFG_W'(64);
			thr_low_q    <= '0;
			thr_high_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_NODE_COUNT:     node_count_q <= cfg_data;
				REG_THRESHOLD_LOW:  thr_low_q    <= cfg_data;
				REG_THRESHOLD_HIGH: thr_high_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Memory addressing and write-back selection
	assign idx_in   = DW'(idx_s1) < n_q;
	assign new_deg  = (deg_rd != '0) ? deg_rd - 1'b1 : deg_rd;
	assign row_addr = q_rd;
	assign deg_addr = i_q;

	always_comb begin
		anc_ra    = v_q;
		anc_we    = 1'b0;
		anc_wa    = v_q;
		anc_wd    = anc_rd | ancu_q;
		deg_we    = 1'b0;
		deg_wd    = new_deg;
		push      = 1'b0;
		push_node = v_q;
		case (state_q)
			S_POPW: anc_ra = q_rd;
			S_CNT:  anc_ra = i_q;
			S_UPD: begin
				anc_we = 1'b1;
				deg_we = 1'b1;
				push   = (new_deg == '0);
			end
			default: ;
		endcase
		if (iv_s1) begin
			anc_we    = 1'b1;
			anc_wa    = idx_s1;
			anc_wd    = idx_in ? (MAX_NODES'(1) << idx_s1) : '0;
			deg_we    = 1'b1;
			deg_wd    = es_deg;
			push      = idx_in && (es_deg == '0);
			push_node = idx_s1;
		end
		if (tail_q == DW'(MAX_NODES)) push = 1'b0;
	end

	always_ff @(posedge clk) begin
		anc_rd <= anc_mem[anc_ra];
		deg_rd <= deg_mem[v_q];
		q_rd   <= q_mem[head_q[NW-1:0]];
		if (anc_we) anc_mem[anc_wa] <= anc_wd;
		if (deg_we) deg_mem[anc_wa] <= deg_wd;
		if (push)   q_mem[tail_q[NW-1:0]] <= push_node;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_ROWW) begin
			row_q  <= es_row;
			ancu_q <= anc_rd;
		end else if (state_q == S_UPD || (state_q == S_SCAN && !row_q[0])) begin
			row_q <= row_q >> 1;
		end
		idx_s1 <= i_q;
	end

	// Sequencer: init, Kahn walk, column count, tally
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q     <= '0;
			i_q     <= '0;
			v_q     <= '0;
			k_q     <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			iv_s1   <= 1'b0;
			cv_s1   <= 1'b0;
		end else begin
			iv_s1 <= (state_q == S_INIT);
			cv_s1 <= (state_q == S_CNT) && (n_q != '0);
			if (push) tail_q <= tail_q + 1'b1;
			case (state_q)
				S_IDLE: begin
					if (accept && cmd.op == OP_COMPUTE) begin
						n_q     <= n_eff;
						i_q     <= '0;
						head_q  <= '0;
						tail_q  <= '0;
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					if (i_q == LAST) state_q <= S_INITD;
					else i_q <= i_q + 1'b1;
				end
				S_INITD: state_q <= S_POP;
				S_POP: begin
					if (head_q == tail_q) begin
						i_q     <= '0;
						state_q <= S_CNT;
					end else begin
						head_q  <= head_q + 1'b1;
						state_q <= S_POPW;
					end
				end
				S_POPW: state_q <= S_ROWW;
				S_ROWW: begin
					v_q     <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (row_q[0]) state_q <= S_UPD;
					else if (v_q == LAST) state_q <= S_POP;
					else v_q <= v_q + 1'b1;
				end
				S_UPD: begin
					if (v_q == LAST) state_q <= S_POP;
					else begin
						v_q     <= v_q + 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_CNT: begin
					if (n_q == '0 || DW'(i_q) == n_q - 1'b1) state_q <= S_CNTD;
					else i_q <= i_q + 1'b1;
				end
				S_CNTD: begin
					k_q     <= '0;
					state_q <= S_TALLY;
				end
				S_TALLY: begin
					if (k_q == n_q) state_q <= S_DONE;
					else k_q <= k_q + 1'b1;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cu_ctrl.clr      = (state_q == S_IDLE) && accept && (cmd.op == OP_COMPUTE);
	assign cu_ctrl.acc_en   = cv_s1;
	assign cu_ctrl.tally_en = (state_q == S_TALLY) && (k_q != n_q);

	adc_count_unit #(.MAX_NODES(MAX_NODES)) u_count (
		.clk(clk), .arst_n(arst_n), .ctrl(cu_ctrl), .row(anc_rd), .n(n_q),
		.thr_low(thr_low_q), .thr_high(thr_high_q), .result(result)
	);
endmodule
